// ===== design/frame_builder_with_padding_assert.svh =====
// Assertion macros for the frame builder.
// Each macro expects clk and rst_n to be visible where it is used.
`ifndef FRAME_BUILDER_WITH_PADDING_ASSERT_SVH
`define FRAME_BUILDER_WITH_PADDING_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define FBP_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset.
`define FBP_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== design/fbp_pkg.sv =====
// Shared types and constants for the frame builder.
// No dependencies; imported by fbp_apb_regs, frame_builder_with_padding and the testbench.
`timescale 1ns / 1ps

package fbp_pkg;

    localparam int WORD_W     = 64;
    localparam int MAC_W      = 48;
    localparam int WC_W       = 12;
    localparam int SEQ_W      = 16;
    localparam int READY_W    = 5;
    localparam int APB_ADDR_W = 4;
    localparam int APB_DATA_W = 64;

    // Register index, taken from paddr[3] (registers sit 8 bytes apart).
    typedef enum logic
    {
        REG_SOURCE_ADDRESS      = 1'b0,
        REG_DESTINATION_ADDRESS = 1'b1
    } reg_index_t;

    typedef struct packed
    {
        logic [MAC_W-1:0] source_address;
        logic [MAC_W-1:0] destination_address;
    } cfg_t;

endpackage

// ===== design/fbp_apb_regs.sv =====
// APB register file holding the source and destination addresses.
// Depends on fbp_pkg for the register index and the configuration struct.
`timescale 1ns / 1ps

module fbp_apb_regs import fbp_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output cfg_t                  cfg
);

    cfg_t       cfg_reg;
    reg_index_t index;
    logic       write_en;

    assign index    = reg_index_t'(paddr[3]);
    assign write_en = psel && penable && pwrite;
    assign cfg      = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else if (write_en)
        begin
            case (index)
                REG_SOURCE_ADDRESS:      cfg_reg.source_address      <= pwdata[MAC_W-1:0];
                REG_DESTINATION_ADDRESS: cfg_reg.destination_address <= pwdata[MAC_W-1:0];
                default:                 cfg_reg <= cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        case (index)
            REG_SOURCE_ADDRESS:
                prdata = {{(APB_DATA_W-MAC_W){1'b0}}, cfg_reg.source_address};
            REG_DESTINATION_ADDRESS:
                prdata = {{(APB_DATA_W-MAC_W){1'b0}}, cfg_reg.destination_address};
            default:
                prdata = '0;
        endcase
    end

endmodule

// ===== design/frame_builder_with_padding.sv =====
// Frame builder: header generation, minimum-length padding and ring buffering.
// An accepted transaction passes through ST_HDR0 and ST_HDR1 on a first mark, ST_DATA, ST_PAD
// for each pad word (at most MIN_FRAME_WORDS), ST_READ and, when a frame is held, ST_RDATA.
// One input transaction at a time, held off by the header, pad and output stall states;
// s_tready returns once the output register has been loaded.
// Ring memories have no reset. Reset (rst_n, async, low) clears pointers and counters.
`timescale 1ns / 1ps
`include "frame_builder_with_padding_assert.svh"

module frame_builder_with_padding import fbp_pkg::*;
#(
    parameter int RING_DEPTH      = 256,
    parameter int MIN_FRAME_WORDS = 6
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    // Input stream.
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [WORD_W-1:0]     s_tdata,   // data_word
    input  logic                  s_tlast,   // last_flag
    input  logic [1:0]            s_tuser,   // [0] first_flag, [1] word_valid
    // Output stream.
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [WORD_W-1:0]     m_tdata,   // out_word
    output logic                  m_tlast,   // out_last
    output logic [1:0]            m_tuser,   // [0] out_first, [1] out_valid
    // Configuration port.
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready
);

    localparam int PTR_W = $clog2(RING_DEPTH);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(RING_DEPTH - 1);
    localparam logic [WC_W-1:0]  MIN_WC   = WC_W'(MIN_FRAME_WORDS);

    // One ring entry: the word plus its first, last and header-word marks.
    typedef struct packed
    {
        logic              hdr;
        logic              last;
        logic              first;
        logic [WORD_W-1:0] word;
    } ring_entry_t;

    // The controller walks one transaction through its ring writes, then one readout.
    typedef enum logic [2:0]
    {
        ST_IDLE,
        ST_HDR0,
        ST_HDR1,
        ST_DATA,
        ST_PAD,
        ST_READ,
        ST_RDATA
    } state_t;

    cfg_t cfg;

    fbp_apb_regs u_regs
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .cfg     (cfg)
    );

    assign pready = 1'b1;

    // The two memories. Each has one write port and one registered read port.
    ring_entry_t       ring_mem [RING_DEPTH];
    logic [WC_W-1:0]   len_mem  [RING_DEPTH];
    ring_entry_t       ring_rd_reg;
    logic [WC_W-1:0]   len_rd_reg;

    logic              ring_we;
    ring_entry_t       ring_wdata;
    logic              len_we;
    logic [WC_W-1:0]   len_wdata;
    logic              rd_en;

    // Control and payload registers.
    state_t            state_reg,       state_next;
    logic [WORD_W-1:0] item_data_reg,   item_data_next;
    logic              item_first_reg,  item_first_next;
    logic              item_last_reg,   item_last_next;
    logic              item_valid_reg,  item_valid_next;
    logic [PTR_W-1:0]  ring_wp_reg,     ring_wp_next;
    logic [PTR_W-1:0]  ring_rp_reg,     ring_rp_next;
    logic [PTR_W-1:0]  len_wp_reg,      len_wp_next;
    logic [PTR_W-1:0]  len_rp_reg,      len_rp_next;
    logic [WC_W-1:0]   word_count_reg,  word_count_next;
    logic              in_frame_reg,    in_frame_next;
    logic [READY_W-1:0] frames_ready_reg, frames_ready_next;
    logic [SEQ_W-1:0]  seq_num_reg,     seq_num_next;
    logic              m_tvalid_reg,    m_tvalid_next;
    logic [WORD_W-1:0] m_tdata_reg,     m_tdata_next;
    logic              m_tlast_reg,     m_tlast_next;
    logic [1:0]        m_tuser_reg,     m_tuser_next;

    logic              out_free;
    logic              store_word;
    logic [WC_W-1:0]   wc_inc;
    logic [WC_W-1:0]   wc_after;
    logic [WORD_W-1:0] read_word;

    function automatic logic [PTR_W-1:0] advance(input logic [PTR_W-1:0] p);
        logic [PTR_W-1:0] n;
        n = (p == PTR_LAST) ? '0 : p + 1'b1;
        return n;
    endfunction

    always_ff @(posedge clk)
    begin
        if (ring_we)
        begin
            ring_mem[ring_wp_reg] <= ring_wdata;
        end
        if (rd_en)
        begin
            ring_rd_reg <= ring_mem[ring_rp_reg];
        end
    end

    always_ff @(posedge clk)
    begin
        if (len_we)
        begin
            len_mem[len_wp_reg] <= len_wdata;
        end
        if (rd_en)
        begin
            len_rd_reg <= len_mem[len_rp_reg];
        end
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tlast  = m_tlast_reg;
    assign m_tuser  = m_tuser_reg;

    // The output register is free when empty or being drained in this cycle.
    assign out_free   = !m_tvalid_reg || m_tready;
    // A data word is kept only inside a frame.
    assign store_word = in_frame_reg && item_valid_reg;
    assign wc_inc     = word_count_reg + 1'b1;
    assign wc_after   = store_word ? wc_inc : word_count_reg;
    // The header data word (hdr mark) carries the stored word count minus one in its low 12 bits.
    assign read_word  = ring_rd_reg.hdr ?
                        {ring_rd_reg.word[WORD_W-1:WC_W], len_rd_reg} : ring_rd_reg.word;

    always_comb
    begin
        state_next        = state_reg;
        item_data_next    = item_data_reg;
        item_first_next   = item_first_reg;
        item_last_next    = item_last_reg;
        item_valid_next   = item_valid_reg;
        ring_wp_next      = ring_wp_reg;
        ring_rp_next      = ring_rp_reg;
        len_wp_next       = len_wp_reg;
        len_rp_next       = len_rp_reg;
        word_count_next   = word_count_reg;
        in_frame_next     = in_frame_reg;
        frames_ready_next = frames_ready_reg;
        seq_num_next      = seq_num_reg;
        m_tvalid_next     = m_tvalid_reg && !m_tready;
        m_tdata_next      = m_tdata_reg;
        m_tlast_next      = m_tlast_reg;
        m_tuser_next      = m_tuser_reg;
        ring_we           = 1'b0;
        ring_wdata        = '0;
        len_we            = 1'b0;
        len_wdata         = wc_after - 1'b1;
        rd_en             = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    item_data_next  = s_tdata;
                    item_first_next = s_tuser[0];
                    item_last_next  = s_tlast;
                    item_valid_next = s_tuser[1];
                    state_next      = s_tuser[0] ? ST_HDR0 : ST_DATA;
                end
            end

            ST_HDR0:
            begin
                // Destination address and upper source bits, marked as frame start.
                ring_we          = 1'b1;
                ring_wdata.first = 1'b1;
                ring_wdata.word  = {cfg.destination_address, cfg.source_address[47:32]};
                ring_wp_next     = advance(ring_wp_reg);
                word_count_next  = '0;
                in_frame_next    = 1'b1;
                state_next       = ST_HDR1;
            end

            ST_HDR1:
            begin
                ring_we         = 1'b1;
                ring_wdata.word = {cfg.source_address[31:0], 16'h0000, seq_num_reg};
                ring_wp_next    = advance(ring_wp_reg);
                seq_num_next    = seq_num_reg + 1'b1;
                state_next      = ST_DATA;
            end

            ST_DATA:
            begin
                if (store_word)
                begin
                    ring_we         = 1'b1;
                    ring_wdata.word = item_data_reg;
                    ring_wdata.hdr  = item_first_reg;
                    ring_wdata.last = item_last_reg &&
                                      ({1'b0, word_count_reg} + 1'b1 >= {1'b0, MIN_WC});
                    ring_wp_next    = advance(ring_wp_reg);
                end
                word_count_next = wc_after;
                state_next      = ST_READ;
                if (item_last_reg)
                begin
                    // Close the frame, record its length and pad it if it is short.
                    in_frame_next     = 1'b0;
                    frames_ready_next = frames_ready_reg + 1'b1;
                    len_we            = 1'b1;
                    len_wp_next       = advance(len_wp_reg);
                    if (wc_after < MIN_WC)
                    begin
                        state_next = ST_PAD;
                    end
                end
            end

            ST_PAD:
            begin
                // One zero word per cycle; the one that reaches the minimum is last.
                ring_we         = 1'b1;
                ring_wdata.last = (wc_inc == MIN_WC);
                ring_wp_next    = advance(ring_wp_reg);
                word_count_next = wc_inc;
                if (wc_inc >= MIN_WC)
                begin
                    state_next = ST_READ;
                end
            end

            ST_READ:
            begin
                if (out_free)
                begin
                    if (frames_ready_reg != '0)
                    begin
                        rd_en      = 1'b1;
                        state_next = ST_RDATA;
                    end
                    else
                    begin
                        // No complete frame stored: emit an empty result.
                        m_tvalid_next = 1'b1;
                        m_tdata_next  = '0;
                        m_tlast_next  = 1'b0;
                        m_tuser_next  = '0;
                        state_next    = ST_IDLE;
                    end
                end
            end

            ST_RDATA:
            begin
                m_tvalid_next = 1'b1;
                m_tdata_next  = read_word;
                m_tlast_next  = ring_rd_reg.last;
                m_tuser_next  = {1'b1, ring_rd_reg.first};
                ring_rp_next  = advance(ring_rp_reg);
                if (ring_rd_reg.hdr)
                begin
                    len_rp_next = advance(len_rp_reg);
                end
                if (ring_rd_reg.last)
                begin
                    frames_ready_next = frames_ready_reg - 1'b1;
                end
                state_next = ST_IDLE;
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            item_data_reg    <= '0;
            item_first_reg   <= 1'b0;
            item_last_reg    <= 1'b0;
            item_valid_reg   <= 1'b0;
            ring_wp_reg      <= '0;
            ring_rp_reg      <= '0;
            len_wp_reg       <= '0;
            len_rp_reg       <= '0;
            word_count_reg   <= '0;
            in_frame_reg     <= 1'b0;
            frames_ready_reg <= '0;
            seq_num_reg      <= '0;
            m_tvalid_reg     <= 1'b0;
            m_tdata_reg      <= '0;
            m_tlast_reg      <= 1'b0;
            m_tuser_reg      <= '0;
        end
        else
        begin
            state_reg        <= state_next;
            item_data_reg    <= item_data_next;
            item_first_reg   <= item_first_next;
            item_last_reg    <= item_last_next;
            item_valid_reg   <= item_valid_next;
            ring_wp_reg      <= ring_wp_next;
            ring_rp_reg      <= ring_rp_next;
            len_wp_reg       <= len_wp_next;
            len_rp_reg       <= len_rp_next;
            word_count_reg   <= word_count_next;
            in_frame_reg     <= in_frame_next;
            frames_ready_reg <= frames_ready_next;
            seq_num_reg      <= seq_num_next;
            m_tvalid_reg     <= m_tvalid_next;
            m_tdata_reg      <= m_tdata_next;
            m_tlast_reg      <= m_tlast_next;
            m_tuser_reg      <= m_tuser_next;
        end
    end

    // The readout cycle may only load the output register when it is empty.
    `FBP_ASSERT_NOW(a_rdata_out_free, state_reg == ST_RDATA, !m_tvalid_reg, "output overwritten")
    // A ring read is only issued while a complete frame is stored.
    `FBP_ASSERT_NOW(a_rdata_has_frame, state_reg == ST_RDATA, frames_ready_reg != '0, "read with no frame")
    // Padding only runs while the frame is below the minimum length.
    `FBP_ASSERT_NOW(a_pad_short, state_reg == ST_PAD, word_count_reg < MIN_WC, "pad past minimum")
    // An accepted transaction always starts with header or data work.
    `FBP_ASSERT_NEXT(a_accept_start, s_tvalid && s_tready, state_reg == ST_HDR0 || state_reg == ST_DATA, "bad start")

endmodule

// ===== tb/sv/frame_builder_with_padding_tb.sv =====
// Self-checking testbench for frame_builder_with_padding: stream traffic and APB setup.
// Depends on fbp_pkg and the frame_builder_with_padding RTL; expectations come from a
// cycle-free predictor of the framing, padding and ring readout kept in this file.
`timescale 1ns / 1ps

module frame_builder_with_padding_tb;
    import fbp_pkg::*;

    localparam int DEPTH       = 256;
    localparam int MIN_WORDS   = 6;
    localparam int CYCLE_LIMIT = 1000000;
    localparam int DRAIN_WAIT  = 16;

    // Bit positions of the per-entry tags in the predicted ring.
    localparam int TAG_FIRST = 0;
    localparam int TAG_LAST  = 1;
    localparam int TAG_HDR   = 2;

    // Slot 0 holds the live prediction; slot 1 is scratch for look-ahead.
    localparam int LIVE  = 0;
    localparam int PROBE = 1;

    typedef struct packed
    {
        logic [WORD_W-1:0] data;
        logic              first;
        logic              last;
        logic              valid;
    } link_word_t;

    typedef struct packed
    {
        logic [WORD_W-1:0] data;
        logic              first;
        logic              last;
        logic              valid;
    } framed_word_t;

    typedef enum int
    {
        FRAME_CLEAN,
        FRAME_HEADLESS,
        FRAME_NO_LAST,
        FRAME_LAST_UNSTORED
    } frame_shape_t;

    logic                  clk;
    logic                  rst_n;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [WORD_W-1:0]     s_tdata;   // data_word
    logic                  s_tlast;   // last_flag
    logic [1:0]            s_tuser;   // [0] first_flag, [1] word_valid
    logic                  m_tvalid;
    logic                  m_tready;
    logic [WORD_W-1:0]     m_tdata;   // out_word
    logic                  m_tlast;   // out_last
    logic [1:0]            m_tuser;   // [0] out_first, [1] out_valid
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [APB_ADDR_W-1:0] paddr;
    logic [APB_DATA_W-1:0] pwdata;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    frame_builder_with_padding
    #(
        .RING_DEPTH      (DEPTH),
        .MIN_FRAME_WORDS (MIN_WORDS)
    )
    uut
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    // Predicted block state. Every array carries a live copy and a scratch copy so that
    // a candidate transaction can be tried out before it is committed.
    logic [MAC_W-1:0]  src_addr;
    logic [MAC_W-1:0]  dst_addr;
    logic [WORD_W-1:0] ring_word   [2][DEPTH];
    logic [2:0]        ring_tag    [2][DEPTH];
    bit                ring_filled [2][DEPTH];
    logic [WC_W-1:0]   span_len    [2][DEPTH];
    bit                span_filled [2][DEPTH];
    logic [7:0]        ring_wp     [2];
    logic [7:0]        ring_rp     [2];
    logic [7:0]        span_wp     [2];
    logic [7:0]        span_rp     [2];
    logic [WC_W-1:0]   frame_words [2];
    bit                framing     [2];
    logic [READY_W-1:0] frames_held [2];
    logic [SEQ_W-1:0]  frame_seq   [2];

    framed_word_t expected_words[$];

    int src_idle_pct;
    int sink_idle_pct;
    int words_taken;
    int error_count;
    int cycle_count;

    // The clock toggles every half period of 4 ns.
    always #4 clk = ~clk;

    // Stop a hung run: the bound is far above the slowest legal run.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Some tests failed");
            $finish;
        end
    end

    // The receiver stalls at random; its rate is set per test phase.
    always @(negedge clk)
    begin
        m_tready <= ($urandom_range(99) >= sink_idle_pct);
    end

    // Only the first ten failures are printed; all of them are counted.
    task automatic note_failure(input string msg);
        error_count++;
        if (error_count <= 10)
            $display("%s", msg);
    endtask

    function automatic void ring_push(input int s, input logic [WORD_W-1:0] w,
                                      input logic [2:0] tag);
        ring_word[s][ring_wp[s]]   = w;
        ring_tag[s][ring_wp[s]]    = tag;
        ring_filled[s][ring_wp[s]] = 1'b1;
        ring_wp[s]                 = ring_wp[s] + 8'd1;
    endfunction

    function automatic void clone_live_state();
        for (int i = 0; i < DEPTH; i++)
        begin
            ring_word[PROBE][i]   = ring_word[LIVE][i];
            ring_tag[PROBE][i]    = ring_tag[LIVE][i];
            ring_filled[PROBE][i] = ring_filled[LIVE][i];
            span_len[PROBE][i]    = span_len[LIVE][i];
            span_filled[PROBE][i] = span_filled[LIVE][i];
        end
        ring_wp[PROBE]     = ring_wp[LIVE];
        ring_rp[PROBE]     = ring_rp[LIVE];
        span_wp[PROBE]     = span_wp[LIVE];
        span_rp[PROBE]     = span_rp[LIVE];
        frame_words[PROBE] = frame_words[LIVE];
        framing[PROBE]     = framing[LIVE];
        frames_held[PROBE] = frames_held[LIVE];
        frame_seq[PROBE]   = frame_seq[LIVE];
    endfunction

    // One step of the framer: header generation on the first mark, storage of a valid
    // word, padding on the last mark, then readout of one word while a frame is held.
    // stale is set when the readout would touch an entry that was never written.
    function automatic void build_frame_step(input int s, input link_word_t in_w,
                                             output framed_word_t out_w, output bit stale);
        logic [2:0]        tag;
        logic [7:0]        rp;
        logic [WORD_W-1:0] w;

        stale = 1'b0;
        if (in_w.first)
        begin
            frame_words[s] = '0;
            framing[s]     = 1'b1;
            tag            = '0;
            tag[TAG_FIRST] = 1'b1;
            ring_push(s, {dst_addr, src_addr[47:32]}, tag);
            ring_push(s, {src_addr[31:0], 16'h0000, frame_seq[s]}, 3'b000);
            frame_seq[s] = frame_seq[s] + 1'b1;
        end

        if (framing[s] && in_w.valid)
        begin
            tag          = '0;
            tag[TAG_LAST] = in_w.last && (int'(frame_words[s]) + 1 >= MIN_WORDS);
            tag[TAG_HDR]  = in_w.first;
            ring_push(s, in_w.data, tag);
            frame_words[s] = frame_words[s] + 1'b1;
        end

        // A last mark closes the frame even with no stored word and even outside a frame.
        if (in_w.last)
        begin
            framing[s]     = 1'b0;
            frames_held[s] = frames_held[s] + 1'b1;
            span_len[s][span_wp[s]]    = frame_words[s] - 1'b1;
            span_filled[s][span_wp[s]] = 1'b1;
            span_wp[s] = span_wp[s] + 8'd1;
            while (int'(frame_words[s]) < MIN_WORDS)
            begin
                frame_words[s] = frame_words[s] + 1'b1;
                tag            = '0;
                tag[TAG_LAST]  = (int'(frame_words[s]) == MIN_WORDS);
                ring_push(s, '0, tag);
            end
        end

        if (frames_held[s] != '0)
        begin
            rp = ring_rp[s];
            if (!ring_filled[s][rp])
                stale = 1'b1;
            w = ring_word[s][rp];
            // The frame's header data word carries the stored word count minus one.
            if (ring_tag[s][rp][TAG_HDR])
            begin
                if (!span_filled[s][span_rp[s]])
                    stale = 1'b1;
                w[WC_W-1:0] = span_len[s][span_rp[s]];
                span_rp[s]  = span_rp[s] + 8'd1;
            end
            out_w.data  = w;
            out_w.first = ring_tag[s][rp][TAG_FIRST];
            out_w.last  = ring_tag[s][rp][TAG_LAST];
            out_w.valid = 1'b1;
            if (ring_tag[s][rp][TAG_LAST])
                frames_held[s] = frames_held[s] - 1'b1;
            ring_rp[s] = rp + 8'd1;
        end
        else
        begin
            out_w = '0;
        end
    endfunction

    function automatic logic [WORD_W-1:0] rand_payload();
        case ($urandom_range(9))
            0:       return '0;
            1:       return '1;
            default: return {$urandom, $urandom};
        endcase
    endfunction

    // Sends one input transaction. The candidate is first run on the scratch state; if
    // it would read a ring or length entry that was never written, it is replaced by a
    // header-plus-last transaction, which always writes the entry about to be read.
    task automatic send_word(input logic [WORD_W-1:0] data, input logic first,
                             input logic last, input logic valid);
        link_word_t   w;
        framed_word_t want;
        bit           stale;

        w = '{data: data, first: first, last: last, valid: valid};
        clone_live_state();
        build_frame_step(PROBE, w, want, stale);
        if (stale)
        begin
            w.first = 1'b1;
            w.last  = 1'b1;
            w.valid = 1'b0;
        end
        words_taken++;
        build_frame_step(LIVE, w, want, stale);

        @(negedge clk);
        while ($urandom_range(99) < src_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= w.data;
        s_tlast  <= w.last;
        s_tuser  <= {w.valid, w.first};
        do
            @(posedge clk);
        while (!s_tready);
        expected_words.push_back(want);
    endtask

    task automatic send_frame(input int len, input frame_shape_t shape);
        logic closes;

        for (int i = 0; i < len; i++)
        begin
            // An occasional empty transaction inside the frame.
            if (i > 0 && $urandom_range(9) == 0)
                send_word(rand_payload(), 1'b0, 1'b0, 1'b0);
            closes = (i == len - 1) && (shape == FRAME_CLEAN || shape == FRAME_HEADLESS);
            send_word(rand_payload(), i == 0, closes, !(i == 0 && shape == FRAME_HEADLESS));
        end
        if (shape == FRAME_LAST_UNSTORED)
            send_word(rand_payload(), 1'b0, 1'b1, 1'b0);
    endtask

    // The sender drops tvalid first so that no transaction is taken twice while it waits.
    task automatic wait_for_results();
        @(negedge clk);
        s_tvalid <= 1'b0;
        while (expected_words.size() != 0)
            @(posedge clk);
    endtask

    // One APB transfer: setup cycle, then access cycle until pready.
    task automatic apb_transfer(input reg_index_t idx, input logic is_write,
                                input logic [APB_DATA_W-1:0] wdata,
                                output logic [APB_DATA_W-1:0] rdata);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= is_write;
        paddr   <= {idx, 3'b000};
        pwdata  <= wdata;
        @(negedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        rdata = prdata;
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // Writes an address register, mirrors it in the predictor and reads it back.
    task automatic program_address(input reg_index_t idx, input logic [APB_DATA_W-1:0] value);
        logic [APB_DATA_W-1:0] readback;
        logic [APB_DATA_W-1:0] dummy;

        apb_transfer(idx, 1'b1, value, dummy);
        if (idx == REG_SOURCE_ADDRESS)
            src_addr = value[MAC_W-1:0];
        else
            dst_addr = value[MAC_W-1:0];
        apb_transfer(idx, 1'b0, '0, readback);
        if (readback !== {16'h0000, value[MAC_W-1:0]})
            note_failure($sformatf("register %s readback: expected %h, got %h",
                                   idx.name(), {16'h0000, value[MAC_W-1:0]}, readback));
    endtask

    // Each output transaction is compared with the oldest prediction.
    always @(posedge clk)
    begin : check_output
        framed_word_t want;

        if (rst_n && m_tvalid && m_tready)
        begin
            if (expected_words.size() == 0)
            begin
                note_failure($sformatf("unexpected output: data %h first %b last %b valid %b",
                                       m_tdata, m_tuser[0], m_tlast, m_tuser[1]));
            end
            else
            begin
                want = expected_words.pop_front();
                if (m_tdata !== want.data || m_tuser[0] !== want.first ||
                    m_tlast !== want.last || m_tuser[1] !== want.valid)
                    note_failure($sformatf(
                        "output mismatch: expected %h/%b/%b/%b, got %h/%b/%b/%b",
                        want.data, want.first, want.last, want.valid,
                        m_tdata, m_tuser[0], m_tlast, m_tuser[1]));
            end
        end
    end

    // Extremes of both addresses, upper data bits beyond the 48-bit field included.
    task automatic test_registers();
        program_address(REG_SOURCE_ADDRESS, '1);
        program_address(REG_DESTINATION_ADDRESS, '0);
        program_address(REG_SOURCE_ADDRESS, '0);
        program_address(REG_DESTINATION_ADDRESS, '1);
        program_address(REG_SOURCE_ADDRESS, {$urandom, $urandom});
        program_address(REG_DESTINATION_ADDRESS, {$urandom, $urandom});
        program_address(REG_SOURCE_ADDRESS, '1);
        program_address(REG_DESTINATION_ADDRESS, '0);
    endtask

    task automatic test_directed_frames();
        // Single-word frame with first, last and valid together: five pad words follow.
        send_word('1, 1'b1, 1'b1, 1'b1);
        // Exactly six stored words with an empty transaction in the middle: no padding.
        send_word('0, 1'b1, 1'b0, 1'b1);
        send_word('1, 1'b0, 1'b0, 1'b1);
        send_word(64'h0123_4567_89ab_cdef, 1'b0, 1'b0, 1'b0);
        send_word(64'h8000_0000_0000_0001, 1'b0, 1'b0, 1'b1);
        send_word(64'hfedc_ba98_7654_3210, 1'b0, 1'b0, 1'b1);
        send_word(64'h5555_aaaa_5555_aaaa, 1'b0, 1'b0, 1'b1);
        send_word(64'haaaa_5555_aaaa_5555, 1'b0, 1'b1, 1'b1);
        // First mark without a valid word: the frame has no header data word.
        send_word(64'hffff_0000_ffff_0000, 1'b1, 1'b0, 1'b0);
        send_word(64'h0000_ffff_0000_ffff, 1'b0, 1'b0, 1'b1);
        send_word('1, 1'b0, 1'b1, 1'b1);
        // A valid word outside any frame is dropped.
        send_word(64'hdead_beef_dead_beef, 1'b0, 1'b0, 1'b1);
        // A last mark outside a frame and without a valid word still closes a frame.
        send_word('0, 1'b0, 1'b1, 1'b0);
        // Header and last in one transaction with no stored word.
        send_word('1, 1'b1, 1'b1, 1'b0);
        // Long frame ended by a last mark on an unstored word: readout runs past it.
        send_word({$urandom, $urandom}, 1'b1, 1'b0, 1'b1);
        for (int i = 0; i < 6; i++)
            send_word({$urandom, $urandom}, 1'b0, 1'b0, 1'b1);
        send_word('0, 1'b0, 1'b1, 1'b0);
    endtask

    // Mostly well-formed frames with random content, the rest noise and broken frames.
    task automatic test_random_traffic(input int src_pct, input int sink_pct, input int quota,
                                       input logic [APB_DATA_W-1:0] src_value,
                                       input logic [APB_DATA_W-1:0] dst_value);
        int start;
        int pick;

        wait_for_results();
        program_address(REG_SOURCE_ADDRESS, src_value);
        program_address(REG_DESTINATION_ADDRESS, dst_value);
        src_idle_pct  = src_pct;
        sink_idle_pct = sink_pct;
        start = words_taken;
        while (words_taken - start < quota)
        begin
            pick = $urandom_range(99);
            if (pick < 75)
                send_frame(($urandom_range(7) == 0) ? $urandom_range(1, 20)
                                                    : $urandom_range(1, 8), FRAME_CLEAN);
            else if (pick < 88)
                send_word(rand_payload(), 1'($urandom_range(1)), 1'($urandom_range(1)),
                          1'($urandom_range(1)));
            else if (pick < 97)
                send_frame($urandom_range(1, 10),
                           frame_shape_t'($urandom_range(FRAME_HEADLESS, FRAME_LAST_UNSTORED)));
            else if (pick < 98)
            begin
                // A burst of closing marks piles up held frames past the 5-bit count.
                for (int i = 0; i < 36; i++)
                    send_word(rand_payload(), 1'b0, 1'b1, 1'b0);
            end
            else
            begin
                // The sender holds off until every pending output has been seen.
                wait_for_results();
            end
        end
    endtask

    initial
    begin
        clk      = 1'b0;
        rst_n    = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        s_tlast  = 1'b0;
        s_tuser  = '0;
        m_tready = 1'b0;
        psel     = 1'b0;
        penable  = 1'b0;
        pwrite   = 1'b0;
        paddr    = '0;
        pwdata   = '0;
        src_idle_pct  = 18;
        sink_idle_pct = 74;
        words_taken   = 0;
        error_count   = 0;
        cycle_count   = 0;
        src_addr      = '0;
        dst_addr      = '0;
        for (int s = 0; s < 2; s++)
        begin
            for (int i = 0; i < DEPTH; i++)
            begin
                ring_word[s][i]   = '0;
                ring_tag[s][i]    = '0;
                ring_filled[s][i] = 1'b0;
                span_len[s][i]    = '0;
                span_filled[s][i] = 1'b0;
            end
            ring_wp[s]     = '0;
            ring_rp[s]     = '0;
            span_wp[s]     = '0;
            span_rp[s]     = '0;
            frame_words[s] = '0;
            framing[s]     = 1'b0;
            frames_held[s] = '0;
            frame_seq[s]   = '0;
        end

        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_registers();
        test_directed_frames();
        test_random_traffic(18, 74, 540, {$urandom, $urandom}, {$urandom, $urandom});
        test_random_traffic(74, 18, 540, '0, '1);
        test_random_traffic(0, 0, 540, '1, {$urandom, $urandom});

        @(negedge clk);
        s_tvalid <= 1'b0;
        wait_for_results();
        repeat (DRAIN_WAIT) @(posedge clk);
        if (error_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+design
design/fbp_pkg.sv
design/fbp_apb_regs.sv
design/frame_builder_with_padding.sv
tb/sv/frame_builder_with_padding_tb.sv
